@@ rtl/core/cbl_pkg.sv @@
// ----------------------------------------------------------------------------
// cbl_pkg
// Shared types and codes of the counted blinker: item structs, the
// configuration struct, input modes and the start, stop and break codes.
// ----------------------------------------------------------------------------
package cbl_pkg;

  // input item
  typedef struct packed {
    logic [1:0] mode;
    logic       switch_value;
    logic [7:0] blink_count;
    logic       feedback_valid;
    logic [6:0] feedback_level;
  } cbl_in_t;

  // result item
  typedef struct packed {
    logic       send_output;
    logic [6:0] output_level;
    logic       active_changed;
    logic       blinking_active;
  } cbl_out_t;

  // configuration registers
  typedef struct packed {
    logic [31:0] on_time_ms;
    logic [31:0] off_time_ms;
    logic [7:0]  count_setting;
    logic        output_is_percent;
    logic [14:0] percent_levels;
    logic [1:0]  start_mode;
    logic [1:0]  stop_mode;
    logic [2:0]  break_mode;
  } cbl_cfg_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ON_TIME     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFF_TIME    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COUNT       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_IS_PERCENT  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PCT_LEVELS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_START_MODE  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_STOP_MODE   = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_BREAK_MODE  = 3'd7;

  // input modes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SWITCH = 2'd1;
  localparam logic [1:0] MODE_COUNT  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // start modes
  localparam logic [1:0] START_ON       = 2'd0;
  localparam logic [1:0] START_OFF      = 2'd1;
  localparam logic [1:0] START_OPPOSITE = 2'd2;
  localparam logic [1:0] START_PRIOR    = 2'd3;

  // stop modes
  localparam logic [1:0] STOP_OFF      = 2'd0;
  localparam logic [1:0] STOP_ON       = 2'd1;
  localparam logic [1:0] STOP_PRIOR    = 2'd2;
  localparam logic [1:0] STOP_OPPOSITE = 2'd3;

  // break modes
  localparam logic [2:0] BRK_IGNORE   = 3'd0;
  localparam logic [2:0] BRK_ON       = 3'd1;
  localparam logic [2:0] BRK_OFF      = 3'd2;
  localparam logic [2:0] BRK_PRIOR    = 3'd3;
  localparam logic [2:0] BRK_OPPOSITE = 3'd4;
  localparam logic [2:0] BRK_SILENT   = 3'd5;

  localparam logic [7:0] AUTO_COUNT  = 8'd255;
  localparam logic [6:0] MAX_PERCENT = 7'd100;

  // reset values of the configuration registers
  localparam logic [31:0] ON_TIME_RST    = 32'd500;
  localparam logic [31:0] OFF_TIME_RST   = 32'd500;
  localparam logic [14:0] PCT_LEVELS_RST = 15'd25600;

endpackage

@@ rtl/core/cbl_engine.sv @@
// ----------------------------------------------------------------------------
// cbl_engine
// Blinker state and the single-pass update that one item makes to it,
// giving the result item of that step.
// ----------------------------------------------------------------------------
module cbl_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  cbl_pkg::cbl_in_t  item,
  input  cbl_pkg::cbl_cfg_t cfg,
  output cbl_pkg::cbl_out_t res
);
  import cbl_pkg::*;

  // blinker state
  logic        running_r, running_nxt;
  logic        phase_on_r, phase_on_nxt;
  logic [6:0]  saved_level_r, saved_level_nxt;
  logic [8:0]  changes_left_r, changes_left_nxt;
  logic [31:0] phase_elapsed_r, phase_elapsed_nxt;
  logic [6:0]  last_level_r, last_level_nxt;
  logic        last_known_r, last_known_nxt;
  logic        auto_started_r, auto_started_nxt;

  logic [6:0]  pct_on, pct_off;

  // start path
  logic [7:0]  start_count;
  logic        fb_use, have_prior;
  logic [6:0]  prior_raw, prior_clamp;
  logic        b_prior, b_phase, b_counted, b_dec;
  logic [6:0]  b_saved;
  logic [8:0]  b_changes;

  // tick path
  logic [31:0] phase_time, elapsed_inc, elapsed_rem;
  logic        reached;
  logic [8:0]  changes_dec;

  logic        opp_on;
  logic        do_begin, do_break, do_halt, emit_en, active_tx;
  logic [6:0]  emit_lvl;

  function automatic logic [6:0] bool_level(input logic on, input logic pct,
                                            input logic [6:0] lon,
                                            input logic [6:0] loff);
    logic [6:0] lvl;
    if (pct) begin
      lvl = on ? lon : loff;
    end else begin
      lvl = {6'd0, on};
    end
    return lvl;
  endfunction

  // percent levels clamped to 100
  assign pct_on  = (cfg.percent_levels[14:8] > MAX_PERCENT) ? MAX_PERCENT
                                                            : cfg.percent_levels[14:8];
  assign pct_off = (cfg.percent_levels[7:0] > {1'b0, MAX_PERCENT}) ? MAX_PERCENT
                                                                   : cfg.percent_levels[6:0];

  // prior level sampled on start
  assign start_count = (item.mode == MODE_COUNT) ? item.blink_count : cfg.count_setting;
  assign fb_use      = (cfg.count_setting != AUTO_COUNT) && item.feedback_valid;
  assign have_prior  = fb_use || last_known_r;
  assign prior_raw   = fb_use ? item.feedback_level : last_level_r;
  assign prior_clamp = (prior_raw > MAX_PERCENT) ? MAX_PERCENT : prior_raw;

  always_comb begin
    if (cfg.output_is_percent) begin
      b_saved = have_prior ? prior_clamp : pct_off;
      b_prior = have_prior && (prior_clamp != pct_off);
    end else begin
      b_prior = have_prior && (prior_raw != 7'd0);
      b_saved = {6'd0, b_prior};
    end
  end

  // phase changes until the end of a counted run
  assign b_counted = (cfg.count_setting != AUTO_COUNT) && (cfg.count_setting != 8'd0);
  assign b_dec     = ((cfg.stop_mode == STOP_OFF) && b_prior)
                  || ((cfg.stop_mode == STOP_ON) && !b_prior)
                  || (cfg.stop_mode == STOP_PRIOR);
  assign b_changes = b_counted ? ({start_count, 1'b0} - {8'd0, b_dec}) : 9'd0;

  // first phase
  always_comb begin
    unique case (cfg.start_mode)
      START_ON:       b_phase = 1'b1;
      START_OFF:      b_phase = 1'b0;
      START_OPPOSITE: b_phase = !b_prior;
      START_PRIOR:    b_phase = b_prior;
    endcase
  end

  // phase timing, saturating at the top
  assign phase_time  = phase_on_r ? cfg.on_time_ms : cfg.off_time_ms;
  assign elapsed_inc = (&phase_elapsed_r) ? phase_elapsed_r : phase_elapsed_r + 32'd1;
  assign reached     = elapsed_inc >= phase_time;
  assign elapsed_rem = elapsed_inc - phase_time;
  assign changes_dec = changes_left_r - 9'd1;

  // opposite of the saved prior level
  assign opp_on = cfg.output_is_percent ? (saved_level_r == pct_off)
                                        : (saved_level_r == 7'd0);

  // step decode and state update
  always_comb begin
    running_nxt       = running_r;
    phase_on_nxt      = phase_on_r;
    saved_level_nxt   = saved_level_r;
    changes_left_nxt  = changes_left_r;
    phase_elapsed_nxt = phase_elapsed_r;
    last_level_nxt    = last_level_r;
    last_known_nxt    = last_known_r;
    auto_started_nxt  = auto_started_r;
    do_begin  = 1'b0;
    do_break  = 1'b0;
    do_halt   = 1'b0;
    emit_en   = 1'b0;
    emit_lvl  = 7'd0;
    active_tx = 1'b0;

    unique case (item.mode)
      MODE_TICK: begin
        if ((cfg.count_setting == AUTO_COUNT) && !auto_started_r) begin
          auto_started_nxt = 1'b1;
          do_begin         = 1'b1;
        end else if (running_r) begin
          phase_elapsed_nxt = elapsed_inc;
          if (reached) begin
            phase_elapsed_nxt = elapsed_rem;
            phase_on_nxt      = !phase_on_r;
            if (changes_left_r == 9'd0) begin
              emit_en  = 1'b1;
              emit_lvl = bool_level(!phase_on_r, cfg.output_is_percent, pct_on, pct_off);
            end else begin
              changes_left_nxt = changes_dec;
              if (changes_dec != 9'd0) begin
                emit_en  = 1'b1;
                emit_lvl = bool_level(!phase_on_r, cfg.output_is_percent, pct_on, pct_off);
              end else begin
                do_halt = 1'b1;
                emit_en = 1'b1;
                unique case (cfg.stop_mode)
                  STOP_OFF:
                    emit_lvl = bool_level(1'b0, cfg.output_is_percent, pct_on, pct_off);
                  STOP_ON:
                    emit_lvl = bool_level(1'b1, cfg.output_is_percent, pct_on, pct_off);
                  STOP_PRIOR:
                    emit_lvl = saved_level_r;
                  STOP_OPPOSITE:
                    emit_lvl = bool_level(opp_on, cfg.output_is_percent, pct_on, pct_off);
                endcase
              end
            end
          end
        end
      end
      MODE_SWITCH: begin
        do_begin = item.switch_value;
        do_break = !item.switch_value;
      end
      MODE_COUNT: begin
        do_begin = (item.blink_count != 8'd0);
        do_break = (item.blink_count == 8'd0);
      end
      MODE_NONE: begin
        do_begin = 1'b0;
      end
    endcase

    // start of blinking
    if (do_begin) begin
      saved_level_nxt   = b_saved;
      changes_left_nxt  = b_changes;
      phase_elapsed_nxt = 32'd0;
      running_nxt       = 1'b1;
      phase_on_nxt      = b_phase;
      active_tx         = 1'b1;
      emit_en           = 1'b1;
      emit_lvl          = bool_level(b_phase, cfg.output_is_percent, pct_on, pct_off);
    end

    // break request
    if (do_break) begin
      unique case (cfg.break_mode)
        BRK_ON: begin
          do_halt  = 1'b1;
          emit_en  = 1'b1;
          emit_lvl = bool_level(1'b1, cfg.output_is_percent, pct_on, pct_off);
        end
        BRK_OFF: begin
          do_halt  = 1'b1;
          emit_en  = 1'b1;
          emit_lvl = bool_level(1'b0, cfg.output_is_percent, pct_on, pct_off);
        end
        BRK_PRIOR: begin
          do_halt  = 1'b1;
          emit_en  = 1'b1;
          emit_lvl = saved_level_r;
        end
        BRK_OPPOSITE: begin
          do_halt  = 1'b1;
          emit_en  = 1'b1;
          emit_lvl = bool_level(opp_on, cfg.output_is_percent, pct_on, pct_off);
        end
        BRK_SILENT: begin
          do_halt = 1'b1;
        end
        default: begin
          do_halt = 1'b0;
        end
      endcase
    end

    // end of blinking
    if (do_halt) begin
      running_nxt       = 1'b0;
      changes_left_nxt  = 9'd0;
      phase_elapsed_nxt = 32'd0;
      active_tx         = 1'b1;
    end

    // remember the last telegram value
    if (emit_en) begin
      last_level_nxt = emit_lvl;
      last_known_nxt = 1'b1;
    end
  end

  // result of this step
  assign res.send_output     = emit_en;
  assign res.output_level    = emit_en ? emit_lvl : 7'd0;
  assign res.active_changed  = active_tx;
  assign res.blinking_active = running_nxt;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r       <= 1'b0;
      phase_on_r      <= 1'b0;
      saved_level_r   <= 7'd0;
      changes_left_r  <= 9'd0;
      phase_elapsed_r <= 32'd0;
      last_level_r    <= 7'd0;
      last_known_r    <= 1'b0;
      auto_started_r  <= 1'b0;
    end else if (fire) begin
      running_r       <= running_nxt;
      phase_on_r      <= phase_on_nxt;
      saved_level_r   <= saved_level_nxt;
      changes_left_r  <= changes_left_nxt;
      phase_elapsed_r <= phase_elapsed_nxt;
      last_level_r    <= last_level_nxt;
      last_known_r    <= last_known_nxt;
      auto_started_r  <= auto_started_nxt;
    end
  end

endmodule

@@ rtl/core/counted_blinker_top.sv @@
// ----------------------------------------------------------------------------
// counted_blinker_top
// Event driven blinker with on/off phase timing and an optional blink count.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output is not stalled and
// returns exactly one result item for each: tick, start and break items all go
// through the same path. An item is captured in an input register, the blinker
// state update and the result are worked out in one pass from that register,
// and the result sits in an output register until taken, so the result of an
// item passes from the input register to the output register once that is
// free. The rate is set by that single state update, which runs once per
// cycle while the output register is free; while a result waits the input
// register can take one more item and then holds in_ready low until the result
// is taken. Configuration writes are always taken (cfg_ready is tied high) and
// take effect on the next item; there is no clearing pass after reset.
module counted_blinker_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  cbl_pkg::cbl_in_t               in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cbl_pkg::cbl_out_t              out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cbl_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [cbl_pkg::CfgDataW-1:0]   cfg_data
);
  import cbl_pkg::*;

  cbl_cfg_t cfg_r;
  logic     in_valid_r;
  cbl_in_t  in_item_r;
  logic     out_valid_r;
  cbl_out_t out_item_r;
  cbl_out_t res;
  logic     advance, fire;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time_ms        <= ON_TIME_RST;
      cfg_r.off_time_ms       <= OFF_TIME_RST;
      cfg_r.count_setting     <= 8'd0;
      cfg_r.output_is_percent <= 1'b0;
      cfg_r.percent_levels    <= PCT_LEVELS_RST;
      cfg_r.start_mode        <= START_ON;
      cfg_r.stop_mode         <= STOP_OFF;
      cfg_r.break_mode        <= BRK_IGNORE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ON_TIME:    cfg_r.on_time_ms        <= cfg_data;
        REG_OFF_TIME:   cfg_r.off_time_ms       <= cfg_data;
        REG_COUNT:      cfg_r.count_setting     <= cfg_data[7:0];
        REG_IS_PERCENT: cfg_r.output_is_percent <= cfg_data[0];
        REG_PCT_LEVELS: cfg_r.percent_levels    <= cfg_data[14:0];
        REG_START_MODE: cfg_r.start_mode        <= cfg_data[1:0];
        REG_STOP_MODE:  cfg_r.stop_mode         <= cfg_data[1:0];
        REG_BREAK_MODE: cfg_r.break_mode        <= cfg_data[2:0];
      endcase
    end
  end

  // flow control: the update fires when the output register is free
  assign advance  = !out_valid_r || out_ready;
  assign fire     = in_valid_r && advance;
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // blinker state and step logic
  cbl_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/core/cbl_checker.sv @@
// ----------------------------------------------------------------------------
// cbl_checker
// Port-level checks of the counted blinker, bound to the top level.
// ----------------------------------------------------------------------------
module cbl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input cbl_pkg::cbl_out_t out_item
);
  import cbl_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // no telegram means a zero level
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.send_output |-> out_item.output_level == 7'd0)
    else $error("level set without a telegram");

  // telegram levels never exceed full scale
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.send_output |-> out_item.output_level <= MAX_PERCENT)
    else $error("telegram level above full scale");

  // a status change without a telegram is only a silent stop
  a_silent_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.active_changed && !out_item.send_output
      |-> !out_item.blinking_active)
    else $error("silent status change while blinking");

endmodule

bind counted_blinker_top cbl_checker u_cbl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

@@ tb/counted_blinker_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counted_blinker_top_tb
// Self-checking bench for the counted blinker. A short directed table walks idle
// behavior, every break code, prior and opposite start and stop codes, clipped
// percents and the autostart, then random phases of ticks, starts and breaks run
// under new register settings. Every result item is checked against typed-in gold
// or a bench blinker model, with random idling on the input and result channels.
// ----------------------------------------------------------------------------
module counted_blinker_top_tb;
  import cbl_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 88;
  localparam int          PRINT_MAX   = 100;
  // break codes the block leaves unused
  localparam logic [2:0]  BRK_SPARE6  = 3'd6;
  localparam logic [2:0]  BRK_SPARE7  = 3'd7;

  // one row of the directed table: a register write or an item
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    cbl_in_t             item;
    logic                gold_vld;
    cbl_out_t            gold;
  } dir_row_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  cbl_in_t             in_item    = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  cbl_out_t            out_item;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  // typed-in expectation that travels with a directed item
  logic                item_gold_vld = 1'b0;
  cbl_out_t            item_gold     = '0;

  int                  in_idle_pct  = 7;
  int                  out_idle_pct = 64;
  int                  mismatch_cnt = 0;
  int                  stall_cycles = 0;

  // blinker model state and its copy of the registers
  cbl_cfg_t            cfg_m;
  logic                bl_running, bl_phase_on, bl_last_known, bl_auto;
  logic [6:0]          bl_saved, bl_last;
  logic [8:0]          bl_changes;
  logic [31:0]         bl_elapsed;
  cbl_out_t            telegram;
  cbl_out_t            telegram_q [$];

  dir_row_t            dir_tab [$];

  counted_blinker_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // blinker model
  // ---------------------------------------------------------------------------

  function automatic logic [6:0] pct_clip(input logic [7:0] v);
    return (v > {1'b0, MAX_PERCENT}) ? MAX_PERCENT : v[6:0];
  endfunction

  function automatic logic [6:0] off_pct();
    return pct_clip(cfg_m.percent_levels[7:0]);
  endfunction

  // telegram level of an on or off state
  function automatic logic [6:0] level_of(input logic on);
    if (cfg_m.output_is_percent) begin
      return on ? pct_clip({1'b0, cfg_m.percent_levels[14:8]}) : off_pct();
    end
    return {6'd0, on};
  endfunction

  function automatic logic [6:0] opposite_level();
    if (cfg_m.output_is_percent) begin
      return level_of(bl_saved == off_pct());
    end
    return level_of(bl_saved == 7'd0);
  endfunction

  function automatic void send_level(input logic [6:0] lvl);
    telegram.send_output  = 1'b1;
    telegram.output_level = lvl;
    bl_last               = lvl;
    bl_last_known         = 1'b1;
  endfunction

  function automatic void stop_blink();
    bl_running              = 1'b0;
    bl_changes              = '0;
    bl_elapsed              = '0;
    telegram.active_changed = 1'b1;
  endfunction

  function automatic void start_blink(input logic [7:0] count, input logic fbv,
                                      input logic [6:0] fbl);
    logic       have;
    logic       prior;
    logic [6:0] lvl;
    have  = 1'b0;
    prior = 1'b0;
    lvl   = '0;
    // prior level: feedback first, then the last telegram
    if (cfg_m.count_setting != AUTO_COUNT && fbv) begin
      have = 1'b1;
      lvl  = fbl;
    end else if (bl_last_known) begin
      have = 1'b1;
      lvl  = bl_last;
    end
    if (cfg_m.output_is_percent) begin
      if (have) begin
        bl_saved = pct_clip({1'b0, lvl});
        prior    = (bl_saved != off_pct());
      end else begin
        bl_saved = off_pct();
        prior    = 1'b0;
      end
    end else begin
      prior    = have && (lvl != 7'd0);
      bl_saved = {6'd0, prior};
    end
    // counted run only with a default count of 1..254
    if (cfg_m.count_setting != AUTO_COUNT && cfg_m.count_setting != 8'd0) begin
      bl_changes = {count, 1'b0};
      if ((cfg_m.stop_mode == STOP_OFF && prior) || (cfg_m.stop_mode == STOP_ON && !prior) ||
          cfg_m.stop_mode == STOP_PRIOR) begin
        bl_changes = bl_changes - 9'd1;
      end
    end else begin
      bl_changes = '0;
    end
    bl_elapsed = '0;
    bl_running = 1'b1;
    case (cfg_m.start_mode)
      START_ON:       bl_phase_on = 1'b1;
      START_OFF:      bl_phase_on = 1'b0;
      START_OPPOSITE: bl_phase_on = !prior;
      default:        bl_phase_on = prior;
    endcase
    telegram.active_changed = 1'b1;
    send_level(level_of(bl_phase_on));
  endfunction

  function automatic void break_blink();
    case (cfg_m.break_mode)
      BRK_ON: begin
        stop_blink();
        send_level(level_of(1'b1));
      end
      BRK_OFF: begin
        stop_blink();
        send_level(level_of(1'b0));
      end
      BRK_PRIOR: begin
        stop_blink();
        send_level(bl_saved);
      end
      BRK_OPPOSITE: begin
        stop_blink();
        send_level(opposite_level());
      end
      BRK_SILENT: stop_blink();
      default: ;
    endcase
  endfunction

  // expected telegram of one item, advancing the model state
  function automatic cbl_out_t next_telegram(input cbl_in_t it);
    logic [31:0] span;
    telegram = '0;
    case (it.mode)
      MODE_TICK: begin
        if (cfg_m.count_setting == AUTO_COUNT && !bl_auto) begin
          // autostart tick does no phase timing
          bl_auto = 1'b1;
          start_blink(cfg_m.count_setting, it.feedback_valid, it.feedback_level);
        end else if (bl_running) begin
          span = bl_phase_on ? cfg_m.on_time_ms : cfg_m.off_time_ms;
          if (bl_elapsed != '1) bl_elapsed = bl_elapsed + 32'd1;
          if (bl_elapsed >= span) begin
            bl_elapsed  = bl_elapsed - span;
            bl_phase_on = !bl_phase_on;
            if (bl_changes == 9'd0) begin
              send_level(level_of(bl_phase_on));
            end else begin
              bl_changes = bl_changes - 9'd1;
              if (bl_changes != 9'd0) begin
                send_level(level_of(bl_phase_on));
              end else begin
                // last phase change of a counted run
                stop_blink();
                case (cfg_m.stop_mode)
                  STOP_OFF:   send_level(level_of(1'b0));
                  STOP_ON:    send_level(level_of(1'b1));
                  STOP_PRIOR: send_level(bl_saved);
                  default:    send_level(opposite_level());
                endcase
              end
            end
          end
        end
      end
      MODE_SWITCH: begin
        if (it.switch_value) begin
          start_blink(cfg_m.count_setting, it.feedback_valid, it.feedback_level);
        end else begin
          break_blink();
        end
      end
      MODE_COUNT: begin
        if (it.blink_count != 8'd0) begin
          start_blink(it.blink_count, it.feedback_valid, it.feedback_level);
        end else begin
          break_blink();
        end
      end
      default: ;
    endcase
    telegram.blinking_active = bl_running;
    return telegram;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_MAX) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // model update on every accepted item and register write, result compare
  always @(posedge clk) begin
    cbl_out_t want;
    if (!rst_n) begin
      cfg_m                = '0;
      cfg_m.on_time_ms     = ON_TIME_RST;
      cfg_m.off_time_ms    = OFF_TIME_RST;
      cfg_m.percent_levels = PCT_LEVELS_RST;
      bl_running           = 1'b0;
      bl_phase_on          = 1'b0;
      bl_last_known        = 1'b0;
      bl_auto              = 1'b0;
      bl_saved             = '0;
      bl_last              = '0;
      bl_changes           = '0;
      bl_elapsed           = '0;
      telegram_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ON_TIME:    cfg_m.on_time_ms        = cfg_data;
          REG_OFF_TIME:   cfg_m.off_time_ms       = cfg_data;
          REG_COUNT:      cfg_m.count_setting     = cfg_data[7:0];
          REG_IS_PERCENT: cfg_m.output_is_percent = cfg_data[0];
          REG_PCT_LEVELS: cfg_m.percent_levels    = cfg_data[14:0];
          REG_START_MODE: cfg_m.start_mode        = cfg_data[1:0];
          REG_STOP_MODE:  cfg_m.stop_mode         = cfg_data[1:0];
          default:        cfg_m.break_mode        = cfg_data[2:0];
        endcase
      end
      if (in_valid && in_ready) begin
        want = next_telegram(in_item);
        telegram_q.push_back(item_gold_vld ? item_gold : want);
      end
      if (out_valid && out_ready) begin
        if (telegram_q.size() == 0) begin
          report_mismatch("result item with no item pending");
        end else begin
          want = telegram_q.pop_front();
          if (out_item.send_output !== want.send_output ||
              out_item.output_level !== want.output_level ||
              out_item.active_changed !== want.active_changed ||
              out_item.blinking_active !== want.blinking_active) begin
            report_mismatch($sformatf(
              "send %0b/%0b level %0d/%0d active_changed %0b/%0b active %0b/%0b (got/exp)",
              out_item.send_output, want.send_output,
              out_item.output_level, want.output_level,
              out_item.active_changed, want.active_changed,
              out_item.blinking_active, want.blinking_active));
          end
        end
      end
    end
  end

  // result channel stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic dir_row_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDataW-1:0] data);
    dir_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.data   = data;
    return row;
  endfunction

  function automatic dir_row_t item_row(input logic [1:0] mode, input logic sw,
                                        input logic [7:0] cnt, input logic fbv,
                                        input logic [6:0] fbl, input logic gv,
                                        input cbl_out_t gold);
    dir_row_t row;
    row                     = '0;
    row.item.mode           = mode;
    row.item.switch_value   = sw;
    row.item.blink_count    = cnt;
    row.item.feedback_valid = fbv;
    row.item.feedback_level = fbl;
    row.gold_vld            = gv;
    row.gold                = gold;
    return row;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_item(input cbl_in_t it, input logic gv, input cbl_out_t gold);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_item       <= it;
    item_gold_vld <= gv;
    item_gold     <= gold;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (telegram_q.size() != 0);
  endtask

  initial begin : stimulus
    cbl_in_t     it;
    int          n;
    int          r;
    logic [31:0] junk;
    logic [31:0] on_t;
    logic [31:0] off_t;
    logic [7:0]  cnt;
    logic [14:0] pct;

    // directed part: gold given where it can be read off directly
    dir_tab = '{
      // idle block: tick, unused mode and breaks do nothing
      item_row(MODE_TICK,   1'b0, 8'd0,   1'b0, 7'd0,   1'b1, {1'b0, 7'd0, 1'b0, 1'b0}),
      item_row(MODE_NONE,   1'b1, 8'd255, 1'b1, 7'd127, 1'b1, {1'b0, 7'd0, 1'b0, 1'b0}),
      item_row(MODE_SWITCH, 1'b0, 8'd0,   1'b0, 7'd0,   1'b1, {1'b0, 7'd0, 1'b0, 1'b0}),
      item_row(MODE_COUNT,  1'b1, 8'd0,   1'b1, 7'd1,   1'b1, {1'b0, 7'd0, 1'b0, 1'b0}),
      cfg_row(REG_ON_TIME, 32'd1),
      cfg_row(REG_OFF_TIME, 32'd1),
      // endless run in switch output, then break to prior
      item_row(MODE_SWITCH, 1'b1, 8'd0,   1'b0, 7'd0,   1'b1, {1'b1, 7'd1, 1'b1, 1'b1}),
      item_row(MODE_TICK,   1'b0, 8'd0,   1'b0, 7'd0,   1'b1, {1'b1, 7'd0, 1'b0, 1'b1}),
      item_row(MODE_TICK,   1'b0, 8'd0,   1'b0, 7'd0,   1'b1, {1'b1, 7'd1, 1'b0, 1'b1}),
      cfg_row(REG_BREAK_MODE, 32'(BRK_PRIOR)),
      item_row(MODE_SWITCH, 1'b0, 8'd0,   1'b0, 7'd0,   1'b1, {1'b1, 7'd0, 1'b1, 1'b0}),
      // percent output with both percents beyond 100
      cfg_row(REG_COUNT, 32'd2),
      cfg_row(REG_IS_PERCENT, 32'd1),
      cfg_row(REG_PCT_LEVELS, 32'h7FFF),
      cfg_row(REG_STOP_MODE, 32'(STOP_PRIOR)),
      item_row(MODE_COUNT,  1'b0, 8'd255, 1'b1, 7'd127, 1'b0, '0),
      item_row(MODE_COUNT,  1'b0, 8'd0,   1'b0, 7'd0,   1'b0, '0),
      // unused break code, counted run ending in the saved level
      cfg_row(REG_PCT_LEVELS, 32'(PCT_LEVELS_RST)),
      cfg_row(REG_START_MODE, 32'(START_PRIOR)),
      cfg_row(REG_BREAK_MODE, 32'(BRK_SPARE6)),
      item_row(MODE_SWITCH, 1'b1, 8'd0,   1'b1, 7'd50,  1'b0, '0),
      item_row(MODE_SWITCH, 1'b0, 8'd0,   1'b0, 7'd0,   1'b1, {1'b0, 7'd0, 1'b0, 1'b1}),
      item_row(MODE_TICK,   1'b0, 8'd0,   1'b0, 7'd0,   1'b0, '0),
      item_row(MODE_TICK,   1'b0, 8'd0,   1'b0, 7'd0,   1'b0, '0),
      item_row(MODE_TICK,   1'b0, 8'd0,   1'b0, 7'd0,   1'b0, '0),
      cfg_row(REG_BREAK_MODE, 32'(BRK_SPARE7)),
      item_row(MODE_SWITCH, 1'b0, 8'd0,   1'b0, 7'd0,   1'b1, {1'b0, 7'd0, 1'b0, 1'b0}),
      // always blinking: autostart on the first tick, extreme phase times
      cfg_row(REG_COUNT, 32'(AUTO_COUNT)),
      cfg_row(REG_ON_TIME, 32'hFFFF_FFFF),
      cfg_row(REG_OFF_TIME, 32'd0),
      item_row(MODE_TICK,   1'b0, 8'd0,   1'b1, 7'd0,   1'b0, '0),
      item_row(MODE_TICK,   1'b0, 8'd0,   1'b0, 7'd0,   1'b0, '0),
      cfg_row(REG_ON_TIME, 32'd0),
      cfg_row(REG_START_MODE, 32'(START_OPPOSITE)),
      cfg_row(REG_STOP_MODE, 32'(STOP_OPPOSITE)),
      cfg_row(REG_BREAK_MODE, 32'(BRK_OPPOSITE)),
      item_row(MODE_TICK,   1'b0, 8'd0,   1'b0, 7'd0,   1'b0, '0),
      item_row(MODE_COUNT,  1'b0, 8'd0,   1'b0, 7'd0,   1'b0, '0),
      cfg_row(REG_BREAK_MODE, 32'(BRK_SILENT)),
      item_row(MODE_SWITCH, 1'b0, 8'd0,   1'b0, 7'd0,   1'b1, {1'b0, 7'd0, 1'b1, 1'b0}),
      item_row(MODE_SWITCH, 1'b1, 8'd0,   1'b1, 7'd100, 1'b0, '0),
      cfg_row(REG_BREAK_MODE, 32'(BRK_ON)),
      item_row(MODE_SWITCH, 1'b0, 8'd0,   1'b0, 7'd0,   1'b0, '0),
      cfg_row(REG_BREAK_MODE, 32'(BRK_OFF)),
      item_row(MODE_COUNT,  1'b0, 8'd0,   1'b0, 7'd0,   1'b0, '0)
    };

    // reset
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_results_done();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
        cfg_valid <= 1'b0;
      end else begin
        send_item(dir_tab[i].item, dir_tab[i].gold_vld, dir_tab[i].gold);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 3) begin
        in_idle_pct  = 64;
        out_idle_pct = 7;
      end else if (ph == 6) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      wait_results_done();

      // short phase times so runs flip and end, with the extremes in a few phases
      on_t  = (ph == 1) ? 32'd0 : (ph == 6) ? 32'hFFFF_FFFF : $urandom_range(1, 3);
      off_t = (ph == 1) ? 32'd0 : (ph == 7) ? 32'hFFFF_FFFF : $urandom_range(1, 3);
      case (ph)
        0, 6:    cnt = 8'd0;
        1:       cnt = 8'd1;
        2, 7:    cnt = AUTO_COUNT;
        4:       cnt = 8'd254;
        default: cnt = 8'($urandom_range(1, 3));
      endcase
      if (ph == 3) begin
        pct = 15'h7FFF;
      end else if (ph == 5) begin
        pct = 15'($urandom());
      end else begin
        pct = {7'($urandom_range(0, 100)), 8'($urandom_range(0, 100))};
      end
      // odd phases put junk above the used bits of the narrow registers
      junk = (ph % 2 == 1) ? $urandom() : 32'd0;
      write_reg(REG_ON_TIME, on_t);
      write_reg(REG_OFF_TIME, off_t);
      write_reg(REG_COUNT, {junk[31:8], cnt});
      write_reg(REG_IS_PERCENT, {junk[31:1], (ph == 1 || ph == 2 || ph == 5 || ph == 6)});
      write_reg(REG_PCT_LEVELS, {junk[31:15], pct});
      write_reg(REG_START_MODE, {junk[31:2], 2'($urandom_range(0, 3))});
      write_reg(REG_STOP_MODE, {junk[31:2], 2'(ph % 4)});
      write_reg(REG_BREAK_MODE, {junk[31:3], 3'(ph)});
      cfg_valid <= 1'b0;

      // mostly ticks between starts, with breaks and unused items mixed in
      n = 0;
      while (n < PHASE_ITEMS) begin
        it.switch_value   = 1'($urandom_range(0, 1));
        it.blink_count    = 8'($urandom());
        it.feedback_valid = 1'($urandom_range(0, 1));
        it.feedback_level = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 1)) :
                                                          7'($urandom());
        r = $urandom_range(0, 99);
        if (r < 80) begin
          it.mode = MODE_TICK;
        end else if (r < 85) begin
          it.mode         = MODE_SWITCH;
          it.switch_value = 1'b1;
        end else if (r < 89) begin
          it.mode         = MODE_SWITCH;
          it.switch_value = 1'b0;
        end else if (r < 97) begin
          it.mode = MODE_COUNT;
          r       = $urandom_range(0, 99);
          if (r < 60) it.blink_count = 8'($urandom_range(1, 3));
          else if (r < 85) it.blink_count = 8'd0;
        end else begin
          it.mode = MODE_NONE;
        end
        send_item(it, 1'b0, '0);
        if (it.mode != MODE_NONE) n++;
      end
    end

    wait_results_done();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
